### rtl/core/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and codes of the deadline timer table: operation and status
// codes, the controller state type and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlScan,
    CtlCommit,
    CtlResult
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming word and restart the scan
    logic scan;    // step the slot scan
    logic commit;  // apply the table update and capture the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

### rtl/core/dtt_ctrl.sv
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer of the deadline timer table: accepts a word, runs the slot scan,
// commits the update and presents the result for one cycle.
// ----------------------------------------------------------------------------
module dtt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dtt_pkg::dp_sts_t sts_i,
  output dtt_pkg::dp_cmd_t cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import dtt_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtlIdle: begin
        if (start_i) begin
          state_d = CtlScan;
        end
      end
      CtlScan: begin
        if (sts_i.scan_done) begin
          state_d = CtlCommit;
        end
      end
      CtlCommit: state_d = CtlResult;
      CtlResult: state_d = CtlIdle;
      default:   state_d = CtlIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      CtlIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      CtlScan:   cmd_o.scan   = 1'b1;
      CtlCommit: cmd_o.commit = 1'b1;
      CtlResult: done_o       = 1'b1;
      default:   busy_o       = 1'b1;
    endcase
  end

endmodule

### rtl/core/dtt_datapath.sv
// ----------------------------------------------------------------------------
// dtt_datapath
// Timer storage, tick counter, slot scan and result registers of the
// deadline timer table.
// ----------------------------------------------------------------------------
module dtt_datapath #(
  parameter int SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dtt_pkg::dp_cmd_t cmd_i,
  output dtt_pkg::dp_sts_t sts_o,
  input  logic [1:0]       opcode_i,
  input  logic [3:0]       slot_i,
  input  logic [31:0]      timeout_i,
  input  logic [7:0]       handler_id_i,
  input  logic [31:0]      argument_i,
  input  logic             done_i,
  output logic [1:0]       status_o,
  output logic [3:0]       created_slot_o,
  output logic             fired_o,
  output logic [3:0]       fired_slot_o,
  output logic [7:0]       fired_handler_o,
  output logic [31:0]      fired_argument_o,
  output logic [31:0]      now_o
);
  import dtt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Storage.
  logic [SLOTS-1:0] valid_q;
  logic [31:0]      dl_mem  [SLOTS];
  logic [7:0]       hdl_mem [SLOTS];
  logic [31:0]      arg_mem [SLOTS];
  logic [31:0]      count_q;

  // Captured word.
  logic [1:0]  op_q;
  logic [3:0]  slot_q;
  logic [31:0] timeout_q;
  logic [7:0]  hdl_in_q;
  logic [31:0] arg_in_q;

  // Scan state.
  logic [CW-1:0] cnt_q;
  logic          cmp_q;
  logic [31:0]   rd_dl_q;
  logic [SW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic          best_found_q;
  logic [SW-1:0] best_idx_q;
  logic [31:0]   best_dl_q;
  logic          free_found_q;
  logic [SW-1:0] free_idx_q;

  // Result registers.
  logic [1:0]    status_q;
  logic [SW-1:0] created_q;
  logic          fired_q;
  logic [SW-1:0] fslot_q;
  logic [7:0]    rd_hdl_q;
  logic [31:0]   rd_arg_q;

  logic [SW-1:0]   scan_addr;
  logic [SW+3:0]   del_ext;
  logic [SW-1:0]   del_idx;
  logic            del_hit;
  logic            create_ok;
  logic [SW+3:0]   created_ext;
  logic [SW+3:0]   fslot_ext;

  assign scan_addr = cnt_q[SW-1:0];
  assign sts_o.scan_done = (cnt_q == CW'(SLOTS));

  assign del_ext   = {{SW{1'b0}}, slot_q};
  assign del_idx   = del_ext[SW-1:0];
  assign del_hit   = (32'(slot_q) < 32'(SLOTS));
  assign create_ok = (timeout_q != 32'd0) && free_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= '0;
      cnt_q   <= '0;
      cmp_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        cmp_q <= 1'b0;
        if (opcode_i == OP_TICK) begin
          count_q <= count_q + 32'd1;
        end
      end else if (cmd_i.scan) begin
        if (!sts_o.scan_done) begin
          cnt_q <= cnt_q + CW'(1);
          cmp_q <= 1'b1;
        end else begin
          cmp_q <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        unique case (op_q)
          OP_TICK: begin
            if (best_found_q) begin
              valid_q[best_idx_q] <= 1'b0;
            end
          end
          OP_CREATE: begin
            if (create_ok) begin
              valid_q[free_idx_q] <= 1'b1;
            end
          end
          OP_DELETE: begin
            if (del_hit) begin
              valid_q[del_idx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Memory ports and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= opcode_i;
      slot_q       <= slot_i;
      timeout_q    <= timeout_i;
      hdl_in_q     <= handler_id_i;
      arg_in_q     <= argument_i;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_dl_q    <= '0;
      free_idx_q   <= '0;
    end
    if (cmd_i.scan && !sts_o.scan_done) begin
      rd_dl_q  <= dl_mem[scan_addr];
      rd_idx_q <= scan_addr;
      rd_vld_q <= valid_q[scan_addr];
    end
    // Compare stage: the earliest expired deadline wins, the lowest slot
    // keeps a tie because only a strictly smaller deadline replaces it.
    if (cmd_i.scan && cmp_q) begin
      if (rd_vld_q && (rd_dl_q <= count_q) &&
          (!best_found_q || (rd_dl_q < best_dl_q))) begin
        best_found_q <= 1'b1;
        best_idx_q   <= rd_idx_q;
        best_dl_q    <= rd_dl_q;
      end
      if (!rd_vld_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
    end
    if (cmd_i.commit) begin
      status_q  <= ST_OK;
      created_q <= '0;
      fired_q   <= 1'b0;
      fslot_q   <= '0;
      rd_hdl_q  <= hdl_mem[best_idx_q];
      rd_arg_q  <= arg_mem[best_idx_q];
      unique case (op_q)
        OP_TICK: begin
          if (best_found_q) begin
            fired_q <= 1'b1;
            fslot_q <= best_idx_q;
          end
        end
        OP_CREATE: begin
          if (timeout_q == 32'd0) begin
            status_q <= ST_ZERO;
          end else if (!free_found_q) begin
            status_q <= ST_FULL;
          end else begin
            created_q           <= free_idx_q;
            dl_mem[free_idx_q]  <= count_q + timeout_q;
            hdl_mem[free_idx_q] <= hdl_in_q;
            arg_mem[free_idx_q] <= arg_in_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign created_ext = {4'b0000, created_q};
  assign fslot_ext   = {4'b0000, fslot_q};

  // Result fields are meaningful only while done is high.
  always_comb begin
    status_o         = '0;
    created_slot_o   = '0;
    fired_o          = 1'b0;
    fired_slot_o     = '0;
    fired_handler_o  = '0;
    fired_argument_o = '0;
    now_o            = count_q;
    if (done_i) begin
      status_o       = status_q;
      created_slot_o = created_ext[3:0];
      fired_o        = fired_q;
      if (fired_q) begin
        fired_slot_o     = fslot_ext[3:0];
        fired_handler_o  = rd_hdl_q;
        fired_argument_o = rd_arg_q;
      end
    end
  end

endmodule

### rtl/core/deadline_timer_table.sv
// ----------------------------------------------------------------------------
// deadline_timer_table
// A word accepted in idle goes through the scan, commit and result states,
// and the next word is accepted only once the controller is back in idle.
// The slot scan reads one deadline from the table memory per cycle.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears the tick count and every valid bit at once; no clearing pass.
// ----------------------------------------------------------------------------
//
// A table of one-shot software timers. Each word carries an opcode:
//   tick   - advances the 32-bit tick count, then fires the valid timer with
//            the smallest deadline at or below the new count (plain unsigned
//            compare, ties to the lowest slot), reporting and freeing it.
//   create - stores handler and argument in the lowest free slot with
//            deadline = count + timeout, rejected for a zero timeout or a
//            full table.
//   delete - frees the given slot; a slot beyond the table is ignored.
// Every word yields exactly one result word, marked by done_o.
//
// The controller (dtt_ctrl) steps through accept, scan, commit and result.
// The datapath (dtt_datapath) holds the valid bits, the deadline, handler and
// argument memories, the scan compare stage and the result registers. The
// scan looks at every slot once, tracking both the earliest expired deadline
// and the lowest free slot, so all three opcodes share one pass.
module deadline_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] timeout_i,
  input  logic [7:0]  handler_id_i,
  input  logic [31:0] argument_i,
  output logic [1:0]  status_o,
  output logic [3:0]  created_slot_o,
  output logic        fired_o,
  output logic [3:0]  fired_slot_o,
  output logic [7:0]  fired_handler_o,
  output logic [31:0] fired_argument_o,
  output logic [31:0] now_o
);
  import dtt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    done;

  dtt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done)
  );

  dtt_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .slot_i          (slot_i),
    .timeout_i       (timeout_i),
    .handler_id_i    (handler_id_i),
    .argument_i      (argument_i),
    .done_i          (done),
    .status_o        (status_o),
    .created_slot_o  (created_slot_o),
    .fired_o         (fired_o),
    .fired_slot_o    (fired_slot_o),
    .fired_handler_o (fired_handler_o),
    .fired_argument_o(fired_argument_o),
    .now_o           (now_o)
  );

  assign done_o = done;

endmodule
